[design/vct_pkg.sv]
// Shared types and constants for the vector clock table.
// Used by vct_row_alu and vector_clock_table; depends on nothing.
package vct_pkg;

  localparam int MaxThreadsDefault = 16;
  localparam int TsW               = 32;
  localparam int IdW               = 4;
  localparam int ModeW             = 3;
  localparam int StatusW           = 2;

  localparam logic [TsW-1:0] Absent = '1;

  typedef enum logic [ModeW-1:0] {
    OP_INIT  = 3'd0,
    OP_ADD   = 3'd1,
    OP_MERGE = 3'd2,
    OP_CMP   = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } mode_e;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StBadId   = 2'd1;
  localparam logic [StatusW-1:0] StFull    = 2'd2;

  typedef struct packed {
    logic a_le_b;
    logic b_le_a;
  } cmp_t;

endpackage

[design/vct_row_mem.sv]
// Row store of the vector clock table: one write port, two registered read ports.
// Depends on nothing outside this file.
module vct_row_mem #(
  parameter int Depth = 16,
  parameter int Width = 512,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[design/vct_row_alu.sv]
// Column-wise signed maximum and happens-before tests over two rows.
// Depends on vct_pkg.
module vct_row_alu #(
  parameter int Cols = vct_pkg::MaxThreadsDefault
) (
  input  logic [Cols-1:0][vct_pkg::TsW-1:0] row_a_i,
  input  logic [Cols-1:0][vct_pkg::TsW-1:0] row_b_i,
  output logic [Cols-1:0][vct_pkg::TsW-1:0] max_o,
  output vct_pkg::cmp_t                     cmp_o
);

  logic [Cols-1:0] a_le_b;
  logic [Cols-1:0] b_le_a;

  always_comb begin
    for (int i = 0; i < Cols; i++) begin
      a_le_b[i] = $signed(row_a_i[i]) <= $signed(row_b_i[i]);
      b_le_a[i] = $signed(row_b_i[i]) <= $signed(row_a_i[i]);
      // take b's entry only where it is strictly larger
      max_o[i]  = b_le_a[i] ? row_a_i[i] : row_b_i[i];
    end
    cmp_o.a_le_b = &a_le_b;
    cmp_o.b_le_a = &b_le_a;
  end

endmodule

[design/vector_clock_table.sv]
// Top level of the vector clock table; depends on vct_pkg, vct_row_mem and vct_row_alu.
// Holds the operation sequencer, row valid bits, thread count and result register.
//
// The block keeps one vector clock row per thread, each row one wide word of
// MAX_THREADS signed 32-bit timestamps in a synchronous memory. After reset every
// row reads as all -1 (absent) and no thread is live, so every defined operation
// but init answers "id out of range" until an init arrives. In the accept cycle
// rows a and b are read from the two memory read ports, and in the execute state
// the rows are compared or merged across all columns at once and the new row is
// written back. A new transaction is taken once the previous one has been written
// back; the single result register lets a finished result wait for the consumer
// while the next transaction is taken, and a further transaction then waits in
// the execute state until that result has gone. Rows never written since the last
// init are marked by a per-row valid bit and read as all absent, so no clearing
// pass is needed after reset or init.
module vector_clock_table #(
  parameter int MAX_THREADS = vct_pkg::MaxThreadsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vct_pkg::ModeW-1:0]    mode_i,
  input  logic [vct_pkg::IdW-1:0]      vec_a_i,
  input  logic [vct_pkg::IdW-1:0]      vec_b_i,
  input  logic [vct_pkg::IdW-1:0]      position_i,
  input  logic signed [vct_pkg::TsW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vct_pkg::StatusW-1:0]  status_o,
  output logic [vct_pkg::IdW-1:0]      new_thread_o,
  output logic                         a_before_b_o,
  output logic                         b_before_a_o,
  output logic                         concurrent_o,
  output logic signed [vct_pkg::TsW-1:0] read_value_o
);

  localparam int IdxW = $clog2(MAX_THREADS);
  localparam int CntW = $clog2(MAX_THREADS + 1);
  localparam int CmpW = (CntW > vct_pkg::IdW) ? CntW : vct_pkg::IdW;
  localparam int RowW = MAX_THREADS * vct_pkg::TsW;

  typedef logic [MAX_THREADS-1:0][vct_pkg::TsW-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [MAX_THREADS-1:0]    valid_q, valid_d;
  logic [CntW-1:0]           count_q, count_d;

  // transaction registers
  vct_pkg::mode_e            mode_q;
  logic [vct_pkg::IdW-1:0]   a_q, b_q, pos_q;
  logic [vct_pkg::TsW-1:0]   val_q;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [vct_pkg::StatusW-1:0] status_q, status_d;
  logic [vct_pkg::IdW-1:0]     child_q, child_d;
  logic                        ab_q, ab_d, ba_q, ba_d, conc_q, conc_d;
  logic [vct_pkg::TsW-1:0]     rd_q, rd_d;

  logic                  accept;
  logic                  work;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  row_t                  mem_wdata;
  logic [RowW-1:0]       rdata_a, rdata_b;
  row_t                  row_a, row_b, row_max;
  vct_pkg::cmp_t         cmp;

  logic [IdxW-1:0]       a_idx, b_idx, pos_idx, cnt_idx;
  logic                  a_ok, b_ok, pos_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  vct_row_mem #(
    .Depth (MAX_THREADS),
    .Width (RowW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (RowW'(mem_wdata)),
    .re_i      (accept),
    .raddr_a_i (IdxW'(vec_a_i)),
    .raddr_b_i (IdxW'(vec_b_i)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign a_idx   = IdxW'(a_q);
  assign b_idx   = IdxW'(b_q);
  assign pos_idx = IdxW'(pos_q);
  assign cnt_idx = IdxW'(count_q);

  // rows not written since the last init read as all absent
  assign row_a = valid_q[a_idx] ? row_t'(rdata_a) : {MAX_THREADS{vct_pkg::Absent}};
  assign row_b = valid_q[b_idx] ? row_t'(rdata_b) : {MAX_THREADS{vct_pkg::Absent}};

  assign a_ok   = CmpW'(a_q)   < CmpW'(count_q);
  assign b_ok   = CmpW'(b_q)   < CmpW'(count_q);
  assign pos_ok = CmpW'(pos_q) < CmpW'(count_q);

  vct_row_alu #(
    .Cols (MAX_THREADS)
  ) u_alu (
    .row_a_i (row_a),
    .row_b_i (row_b),
    .max_o   (row_max),
    .cmp_o   (cmp)
  );

  // Execute in S_EXEC once the result register is free or draining.
  assign work = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    row_t wrow;
    wrow      = row_a;
    mem_we    = 1'b0;
    mem_waddr = a_idx;
    valid_d   = valid_q;
    count_d   = count_q;
    status_d  = vct_pkg::StOk;
    child_d   = '0;
    ab_d      = 1'b0;
    ba_d      = 1'b0;
    conc_d    = 1'b0;
    rd_d      = '0;
    if (work) begin
      case (mode_q)
        vct_pkg::OP_INIT: begin
          wrow      = {MAX_THREADS{vct_pkg::Absent}};
          wrow[0]   = '0;
          mem_we    = 1'b1;
          mem_waddr = '0;
          valid_d   = '0;
          valid_d[0] = 1'b1;
          count_d   = CntW'(1);
        end
        vct_pkg::OP_ADD: begin
          if (!a_ok) begin
            status_d = vct_pkg::StBadId;
          end else if (count_q == CntW'(MAX_THREADS)) begin
            status_d = vct_pkg::StFull;
          end else begin
            // copy the parent, stamp the child's own column
            wrow[cnt_idx]    = '0;
            mem_we           = 1'b1;
            mem_waddr        = cnt_idx;
            valid_d[cnt_idx] = 1'b1;
            count_d          = count_q + CntW'(1);
            child_d          = vct_pkg::IdW'(count_q);
          end
        end
        vct_pkg::OP_MERGE: begin
          if (!a_ok || !b_ok) begin
            status_d = vct_pkg::StBadId;
          end else begin
            wrow           = row_max;
            mem_we         = 1'b1;
            valid_d[a_idx] = 1'b1;
          end
        end
        vct_pkg::OP_CMP: begin
          if (!a_ok || !b_ok) begin
            status_d = vct_pkg::StBadId;
          end else begin
            ab_d   = cmp.a_le_b;
            ba_d   = cmp.b_le_a;
            conc_d = !(cmp.a_le_b || cmp.b_le_a);
          end
        end
        vct_pkg::OP_WRITE: begin
          if (!a_ok || !pos_ok) begin
            status_d = vct_pkg::StBadId;
          end else begin
            wrow[pos_idx]  = val_q;
            mem_we         = 1'b1;
            valid_d[a_idx] = 1'b1;
          end
        end
        vct_pkg::OP_READ: begin
          if (!a_ok || !pos_ok) begin
            status_d = vct_pkg::StBadId;
          end else begin
            rd_d = row_a[pos_idx];
          end
        end
        default: begin
          // unused modes: change nothing, answer ok with zero fields
        end
      endcase
    end
    mem_wdata = wrow;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (work) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the transaction fields for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= vct_pkg::mode_e'(mode_i);
      a_q    <= vec_a_i;
      b_q    <= vec_b_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      status_q <= status_d;
      child_q  <= child_d;
      ab_q     <= ab_d;
      ba_q     <= ba_d;
      conc_q   <= conc_d;
      rd_q     <= rd_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign new_thread_o = child_q;
  assign a_before_b_o = ab_q;
  assign b_before_a_o = ba_q;
  assign concurrent_o = conc_q;
  assign read_value_o = rd_q;

endmodule

[tb/vector_clock_table_test.sv]
// Self-checking testbench for vector_clock_table: a directed table, then random traffic.
// Depends on vct_pkg and the vector_clock_table RTL only; reads no files.
// A local predictor mirrors the clock table and gives the expected result wherever a plan row does not.
module vector_clock_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Threads        = vct_pkg::MaxThreadsDefault;
  localparam int ModeW          = vct_pkg::ModeW;
  localparam int IdW            = vct_pkg::IdW;
  localparam int TsW            = vct_pkg::TsW;
  localparam int StatusW        = vct_pkg::StatusW;
  localparam int RandomPerPhase = 400;
  localparam int PlanLen        = 22;

  typedef struct {
    logic [ModeW-1:0]      mode;
    logic [IdW-1:0]        vec_a;
    logic [IdW-1:0]        vec_b;
    logic [IdW-1:0]        position;
    logic signed [TsW-1:0] value;
  } clock_op_t;

  typedef struct {
    logic [StatusW-1:0]    status;
    logic [IdW-1:0]        new_thread;
    logic                  a_before_b;
    logic                  b_before_a;
    logic                  concurrent;
    logic signed [TsW-1:0] read_value;
  } clock_result_t;

  // One row of the directed plan. Where typed is set, the expected result is
  // taken from the row itself; otherwise the predictor supplies it.
  typedef struct {
    logic [ModeW-1:0]      mode;
    logic [IdW-1:0]        vec_a;
    logic [IdW-1:0]        vec_b;
    logic [IdW-1:0]        position;
    logic signed [TsW-1:0] value;
    int                    reps;
    bit                    typed;
    logic [StatusW-1:0]    status;
    logic [IdW-1:0]        new_thread;
    logic                  a_before_b;
    logic                  b_before_a;
    logic                  concurrent;
    logic signed [TsW-1:0] read_value;
  } plan_row_t;

  // mode, a, b, pos, value, reps, typed, status, child, a<=b, b<=a, conc, read
  plan_row_t directed_plan [PlanLen] = '{
    // nothing is live before the first init, so even id 0 is refused
    '{vct_pkg::OP_READ, 0, 0, 0, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_ADD, 0, 0, 0, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_INIT, 0, 0, 0, 0, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_READ, 0, 0, 0, 0, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    // column 1 is not yet live
    '{vct_pkg::OP_READ, 0, 0, 1, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_READ, 0, 0, 0, 0, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 32'h7FFF_FFFF},
    '{vct_pkg::OP_ADD, 0, 0, 0, 0, 1, 1, vct_pkg::StOk, 1, 0, 0, 0, 0},
    '{vct_pkg::OP_ADD, 15, 0, 0, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0},
    // most negative timestamp, compared as signed
    '{vct_pkg::OP_WRITE, 1, 0, 0, 32'h8000_0000, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_CMP, 1, 0, 0, 0, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_MERGE, 1, 0, 0, 0, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_WRITE, 0, 0, 1, 5, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_CMP, 0, 1, 0, 0, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    // unused modes leave everything alone and answer zeros
    '{3'd6, 15, 15, 15, -1, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{3'd7, 10, 5, 10, 32'h5555_5555, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_CMP, 0, 15, 0, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0},
    // fill the table, then one add too many
    '{vct_pkg::OP_ADD, 1, 0, 0, 0, 14, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_ADD, 0, 0, 0, 0, 1, 1, vct_pkg::StFull, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_WRITE, 15, 0, 15, 32'h8000_0000, 1, 0, vct_pkg::StOk, 0, 0, 0, 0, 0},
    // a second init clears everything again
    '{vct_pkg::OP_INIT, 0, 0, 0, 0, 1, 1, vct_pkg::StOk, 0, 0, 0, 0, 0},
    '{vct_pkg::OP_READ, 1, 0, 0, 0, 1, 1, vct_pkg::StBadId, 0, 0, 0, 0, 0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [ModeW-1:0]      mode_i = '0;
  logic [IdW-1:0]        vec_a_i = '0;
  logic [IdW-1:0]        vec_b_i = '0;
  logic [IdW-1:0]        position_i = '0;
  logic signed [TsW-1:0] value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [IdW-1:0]        new_thread_o;
  logic                  a_before_b_o;
  logic                  b_before_a_o;
  logic                  concurrent_o;
  logic signed [TsW-1:0] read_value_o;

  // Predictor state: the whole clock table and the number of live threads.
  logic signed [TsW-1:0] ts_table [Threads][Threads];
  int                    live_threads;

  clock_result_t pending_results [$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_cycles;

  vector_clock_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .vec_a_i      (vec_a_i),
    .vec_b_i      (vec_b_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .new_thread_o (new_thread_o),
    .a_before_b_o (a_before_b_o),
    .b_before_a_o (b_before_a_o),
    .concurrent_o (concurrent_o),
    .read_value_o (read_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one transaction to the local table and return the result it causes.
  function automatic clock_result_t predict_op(clock_op_t op);
    clock_result_t res;
    bit            a_le_b;
    bit            b_le_a;
    res = '{default: '0};
    case (op.mode)
      vct_pkg::OP_INIT: begin
        foreach (ts_table[r, c]) ts_table[r][c] = vct_pkg::Absent;
        ts_table[0][0] = '0;
        live_threads   = 1;
      end
      vct_pkg::OP_ADD: begin
        if (op.vec_a >= live_threads) begin
          res.status = vct_pkg::StBadId;
        end else if (live_threads >= Threads) begin
          res.status = vct_pkg::StFull;
        end else begin
          res.new_thread = IdW'(live_threads);
          for (int c = 0; c < Threads; c++) ts_table[live_threads][c] = ts_table[op.vec_a][c];
          ts_table[live_threads][live_threads] = '0;
          live_threads++;
        end
      end
      vct_pkg::OP_MERGE: begin
        if (op.vec_a >= live_threads || op.vec_b >= live_threads) begin
          res.status = vct_pkg::StBadId;
        end else begin
          for (int c = 0; c < Threads; c++)
            if (ts_table[op.vec_b][c] > ts_table[op.vec_a][c])
              ts_table[op.vec_a][c] = ts_table[op.vec_b][c];
        end
      end
      vct_pkg::OP_CMP: begin
        if (op.vec_a >= live_threads || op.vec_b >= live_threads) begin
          res.status = vct_pkg::StBadId;
        end else begin
          a_le_b = 1'b1;
          b_le_a = 1'b1;
          // every column takes part, absent entries included
          for (int c = 0; c < Threads; c++) begin
            if (ts_table[op.vec_a][c] > ts_table[op.vec_b][c]) a_le_b = 1'b0;
            if (ts_table[op.vec_b][c] > ts_table[op.vec_a][c]) b_le_a = 1'b0;
          end
          res.a_before_b = a_le_b;
          res.b_before_a = b_le_a;
          res.concurrent = !(a_le_b || b_le_a);
        end
      end
      vct_pkg::OP_WRITE: begin
        if (op.vec_a >= live_threads || op.position >= live_threads)
          res.status = vct_pkg::StBadId;
        else ts_table[op.vec_a][op.position] = op.value;
      end
      vct_pkg::OP_READ: begin
        if (op.vec_a >= live_threads || op.position >= live_threads)
          res.status = vct_pkg::StBadId;
        else res.read_value = ts_table[op.vec_a][op.position];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Pick a row or column id: mostly a live one, now and then anything at all.
  function automatic logic [IdW-1:0] pick_id();
    if (live_threads > 0 && $urandom_range(99) < 88) return IdW'($urandom_range(live_threads - 1));
    return IdW'($urandom_range(15));
  endfunction

  // Small timestamps make merges and compares interesting; extremes come in too.
  function automatic logic signed [TsW-1:0] pick_stamp();
    case ($urandom_range(9))
      6:       return -1;
      7:       return 32'h7FFF_FFFF;
      8:       return 32'h8000_0000;
      9:       return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic clock_op_t random_op();
    clock_op_t op;
    int        roll;
    roll        = $urandom_range(99);
    op.vec_a    = pick_id();
    op.vec_b    = pick_id();
    op.position = pick_id();
    op.value    = pick_stamp();
    if (roll < 3)       op.mode = vct_pkg::OP_INIT;
    else if (roll < 17) op.mode = vct_pkg::OP_ADD;
    else if (roll < 35) op.mode = vct_pkg::OP_MERGE;
    else if (roll < 56) op.mode = vct_pkg::OP_CMP;
    else if (roll < 76) op.mode = vct_pkg::OP_WRITE;
    else if (roll < 96) op.mode = vct_pkg::OP_READ;
    else                op.mode = ModeW'($urandom_range(6, 7));
    return op;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Offer one transaction from a falling edge, hold it until accepted, and
  // queue its expected result. Returns at the following falling edge.
  task automatic send_op(clock_op_t op, bit typed, clock_result_t typed_res);
    clock_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op.mode;
    vec_a_i    <= op.vec_a;
    vec_b_i    <= op.vec_b;
    position_i <= op.position;
    value_i    <= op.value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_op(op);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Receiver: stall at random, or hold off for a whole stretch when asked.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each result taken by the receiver against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    clock_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", status_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (new_thread_o !== want.new_thread)
          report_mismatch($sformatf("new_thread %0d, expected %0d",
                                    new_thread_o, want.new_thread));
        if (a_before_b_o !== want.a_before_b)
          report_mismatch($sformatf("a_before_b %b, expected %b",
                                    a_before_b_o, want.a_before_b));
        if (b_before_a_o !== want.b_before_a)
          report_mismatch($sformatf("b_before_a %b, expected %b",
                                    b_before_a_o, want.b_before_a));
        if (concurrent_o !== want.concurrent)
          report_mismatch($sformatf("concurrent %b, expected %b",
                                    concurrent_o, want.concurrent));
        if (read_value_o !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h",
                                    read_value_o, want.read_value));
      end
    end
  end

  initial begin : stimulus
    clock_op_t     op;
    clock_result_t want;
    fail_count    = 0;
    hold_cycles   = 0;
    send_idle_pct = 21;
    recv_idle_pct = 53;
    foreach (ts_table[r, c]) ts_table[r][c] = vct_pkg::Absent;
    live_threads = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed plan: walk the table, expanding repeated rows.
    for (int i = 0; i < PlanLen; i++) begin
      for (int k = 0; k < directed_plan[i].reps; k++) begin
        op.mode         = directed_plan[i].mode;
        op.vec_a        = directed_plan[i].vec_a;
        op.vec_b        = directed_plan[i].vec_b;
        op.position     = directed_plan[i].position;
        op.value        = directed_plan[i].value;
        want.status     = directed_plan[i].status;
        want.new_thread = directed_plan[i].new_thread;
        want.a_before_b = directed_plan[i].a_before_b;
        want.b_before_a = directed_plan[i].b_before_a;
        want.concurrent = directed_plan[i].concurrent;
        want.read_value = directed_plan[i].read_value;
        send_op(op, directed_plan[i].typed, want);
      end
    end

    // Random traffic in three phases: slow receiver, slow sender, no idling.
    want = '{default: '0};
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 21; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Hold the receiver off for a long stretch so that the block backs up.
          @(posedge clk_i);
          hold_cycles = 80;
          @(negedge clk_i);
        end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) send_op(random_op(), 1'b0, want);
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then wait on for any stragglers.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
